// ----- rtl/lpcc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpcc_pkg: shared types and constants of the lidar point colorizer
// Frame geometry, field widths, register indexes and the item records that
// travel between the projection front end, the queue and the frame store.
// ----------------------------------------------------------------------------
`default_nettype none
package lpcc_pkg;

	localparam int IMAGE_WIDTH  = 1920;
	localparam int IMAGE_HEIGHT = 1080;
	localparam int MAX_DIM      = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
	// Quotient bits produced by the dividers; a quotient at or above 2**Q_W is off frame.
	localparam int Q_W          = $clog2(MAX_DIM);
	localparam int PIX_N        = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int ADDR_W       = $clog2(PIX_N);

	localparam int ROW_W   = 11;
	localparam int COL_W   = 11;
	localparam int COLOR_W = 24;
	localparam int COORD_W = 24;
	localparam int COEF_W  = 32;
	localparam int FRAC_W  = 10;
	localparam int PROD_W  = COEF_W + COORD_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int REM_W   = SUM_W + Q_W;
	localparam int REG_W   = 64;
	localparam int NUM_REGS = 6;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_R0_C01 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_R0_C23 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_R1_C01 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_R1_C23 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_R2_C01 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_R2_C23 = 3'd5;

	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_POINT = 1'b1
	} cmd_t;

	// Color is {red, green, blue} with blue in the low byte.
	typedef struct packed {
		cmd_t                       cmd;
		logic [ROW_W-1:0]           row;
		logic [COL_W-1:0]           col;
		logic [COLOR_W-1:0]         color;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [COORD_W-1:0]  z;
	} req_t;

	typedef struct packed {
		cmd_t                       cmd;
		logic [ADDR_W-1:0]          addr;
		logic [COLOR_W-1:0]         color;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic signed [COORD_W-1:0]  z;
	} item_t;

endpackage
`default_nettype wire

// ----- rtl/lidar_point_camera_colorizer.sv -----
// Path: a request passes the 17 front stages (6 + Q_W, Q_W = 11), then the
//   queue write, the frame store read and the result register.
// Throughput: one request per cycle unless the front end stalls on a full queue; the divider is fully pipelined.
// Reset: arst_n clears the matrix registers and all valid state at once;
//   the frame store is not cleared and holds unknown data until written.
// ----------------------------------------------------------------------------
// lidar_point_camera_colorizer: colors lidar points from a camera frame
// Pixel requests fill a frame store; point requests are projected through a
// 3x4 matrix and, when they land in the frame, leave with that pixel's color.
// ----------------------------------------------------------------------------
`default_nettype none
module lidar_point_camera_colorizer (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [lpcc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [lpcc_pkg::REG_W-1:0]          cfg_data,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire                                s_tuser,   // command
	// pixel_row, pixel_col, pixel_blue, pixel_green, pixel_red,
	// point_x, point_y, point_z, two zero bits
	input  wire [119:0]                        s_tdata,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// out_x, out_y, out_z, color_blue, color_green, color_red
	output logic [95:0]                        m_tdata
);

	lpcc_pkg::req_t   req;
	lpcc_pkg::item_t  push_item, head;
	logic             push, q_full, pop, q_empty;
	logic signed [lpcc_pkg::COORD_W-1:0] ox, oy, oz;
	logic [lpcc_pkg::COLOR_W-1:0]        ocolor;

	// Unpack the request; color is kept as {red, green, blue}.
	always_comb begin
		req.cmd   = lpcc_pkg::cmd_t'(s_tuser);
		req.row   = s_tdata[10:0];
		req.col   = s_tdata[21:11];
		req.color = s_tdata[45:22];
		req.x     = s_tdata[69:46];
		req.y     = s_tdata[93:70];
		req.z     = s_tdata[117:94];
	end

	// The front end projects and classifies; it stalls only when the queue
	// is full and a kept item waits in its last stage.
	lpcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (req),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	// The queue lets the result side stall without blocking projection work
	// that is already in flight.
	lpcc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (head)
	);

	// Pixel writes and point reads leave the queue in request order, so a
	// point always sees every pixel written ahead of it.
	lpcc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (head),
		.pop     (pop),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.m_x     (ox),
		.m_y     (oy),
		.m_z     (oz),
		.m_color (ocolor)
	);

	assign m_tdata = {ocolor, oz, oy, ox};

endmodule
`default_nettype wire

// ----- rtl/lpcc_front.sv -----
// ----------------------------------------------------------------------------
// lpcc_front: projection and classification pipeline
// Holds the projection matrix, projects points, divides by the depth term one
// quotient bit per stage and drops points and pixels that miss the frame.
// ----------------------------------------------------------------------------
`default_nettype none
module lpcc_front (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [lpcc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [lpcc_pkg::REG_W-1:0]        cfg_data,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  lpcc_pkg::req_t                   in_req,
	output logic                             push,
	output lpcc_pkg::item_t                  push_item,
	input  wire                              q_full
);

	localparam int NS = 6 + lpcc_pkg::Q_W;

	typedef struct packed {
		logic             valid;
		logic             keep;
		lpcc_pkg::item_t  item;
	} ctl_t;

	logic [lpcc_pkg::REG_W-1:0]          coef_q [lpcc_pkg::NUM_REGS];
	logic signed [lpcc_pkg::COEF_W-1:0]  coefs [12];
	logic signed [lpcc_pkg::PROD_W-1:0]  prod_d [12];
	logic signed [lpcc_pkg::PROD_W-1:0]  p_s1 [12];
	logic signed [lpcc_pkg::PROD_W:0]    h_s2 [6];
	logic signed [lpcc_pkg::SUM_W-1:0]   t_s3 [3];
	logic [lpcc_pkg::SUM_W-1:0]          mu_s4, mv_s4, mw_s4;
	logic                                negu_s4, negv_s4;
	logic [lpcc_pkg::SUM_W-1:0]          ru [lpcc_pkg::Q_W+1];
	logic [lpcc_pkg::SUM_W-1:0]          rv [lpcc_pkg::Q_W+1];
	logic [lpcc_pkg::SUM_W-1:0]          db [lpcc_pkg::Q_W+1];
	logic [lpcc_pkg::Q_W-1:0]            qu [lpcc_pkg::Q_W+1];
	logic [lpcc_pkg::Q_W-1:0]            qv [lpcc_pkg::Q_W+1];
	logic                                nu [lpcc_pkg::Q_W+1];
	logic                                nv [lpcc_pkg::Q_W+1];
	ctl_t                                ctl_q [1:NS];
	ctl_t                                ctl_d [1:NS];
	logic                                en, out_v;
	logic [lpcc_pkg::REM_W-1:0]          lim_s5;
	logic                                x_pos_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lpcc_pkg::NUM_REGS; i++) coef_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpcc_pkg::REG_R0_C01: coef_q[0] <= cfg_data;
				lpcc_pkg::REG_R0_C23: coef_q[1] <= cfg_data;
				lpcc_pkg::REG_R1_C01: coef_q[2] <= cfg_data;
				lpcc_pkg::REG_R1_C23: coef_q[3] <= cfg_data;
				lpcc_pkg::REG_R2_C01: coef_q[4] <= cfg_data;
				lpcc_pkg::REG_R2_C23: coef_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Coefficient c of row r sits in word 2r + c/2, odd c in the high half.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 4; c++) begin
				coefs[r*4+c] = (c % 2 == 1) ? coef_q[r*2 + c/2][63:32]
				                            : coef_q[r*2 + c/2][31:0];
			end
		end
		for (int r = 0; r < 3; r++) begin
			prod_d[r*4+0] = coefs[r*4+0] * in_req.x;
			prod_d[r*4+1] = coefs[r*4+1] * in_req.y;
			prod_d[r*4+2] = coefs[r*4+2] * in_req.z;
			prod_d[r*4+3] = {{(lpcc_pkg::PROD_W-lpcc_pkg::COEF_W-lpcc_pkg::FRAC_W)
			                   {coefs[r*4+3][lpcc_pkg::COEF_W-1]}},
			                 coefs[r*4+3], {lpcc_pkg::FRAC_W{1'b0}}};
		end
	end

	assign out_v     = ctl_q[NS].valid && ctl_q[NS].keep;
	assign en        = !out_v || !q_full;
	assign in_ready  = en;
	assign push      = out_v && !q_full;
	assign push_item = ctl_q[NS].item;
	assign x_pos_s3  = !ctl_q[3].item.x[lpcc_pkg::COORD_W-1] && (ctl_q[3].item.x != '0);
	assign lim_s5    = {{lpcc_pkg::Q_W{1'b0}}, mw_s4} << lpcc_pkg::Q_W;

	// Arithmetic stages ahead of the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 12; i++) p_s1[i] <= prod_d[i];
			for (int i = 0; i < 6; i++) h_s2[i] <= p_s1[2*i] + p_s1[2*i+1];
			for (int i = 0; i < 3; i++) t_s3[i] <= h_s2[2*i] + h_s2[2*i+1];
			mu_s4   <= t_s3[0][lpcc_pkg::SUM_W-1] ? -t_s3[0] : t_s3[0];
			mv_s4   <= t_s3[1][lpcc_pkg::SUM_W-1] ? -t_s3[1] : t_s3[1];
			mw_s4   <= t_s3[2][lpcc_pkg::SUM_W-1] ? -t_s3[2] : t_s3[2];
			negu_s4 <= t_s3[0][lpcc_pkg::SUM_W-1] ^ t_s3[2][lpcc_pkg::SUM_W-1];
			negv_s4 <= t_s3[1][lpcc_pkg::SUM_W-1] ^ t_s3[2][lpcc_pkg::SUM_W-1];
			ru[0]   <= mu_s4;
			rv[0]   <= mv_s4;
			db[0]   <= mw_s4;
			qu[0]   <= '0;
			qv[0]   <= '0;
			nu[0]   <= negu_s4;
			nv[0]   <= negv_s4;
		end
	end

	// Restoring division of |u| and |v| by |w|, one quotient bit per stage.
	for (genvar k = 1; k <= lpcc_pkg::Q_W; k++) begin : g_div
		localparam int BIT = lpcc_pkg::Q_W - k;
		logic [lpcc_pkg::REM_W-1:0] sh;
		logic [lpcc_pkg::REM_W-1:0] dif_u, dif_v;
		logic                       ge_u, ge_v;

		always_comb begin
			sh    = {{lpcc_pkg::Q_W{1'b0}}, db[k-1]} << BIT;
			ge_u  = {{lpcc_pkg::Q_W{1'b0}}, ru[k-1]} >= sh;
			ge_v  = {{lpcc_pkg::Q_W{1'b0}}, rv[k-1]} >= sh;
			dif_u = {{lpcc_pkg::Q_W{1'b0}}, ru[k-1]} - sh;
			dif_v = {{lpcc_pkg::Q_W{1'b0}}, rv[k-1]} - sh;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ru[k] <= ge_u ? dif_u[lpcc_pkg::SUM_W-1:0] : ru[k-1];
				rv[k] <= ge_v ? dif_v[lpcc_pkg::SUM_W-1:0] : rv[k-1];
				db[k] <= db[k-1];
				qu[k] <= qu[k-1] | (lpcc_pkg::Q_W'(ge_u) << BIT);
				qv[k] <= qv[k-1] | (lpcc_pkg::Q_W'(ge_v) << BIT);
				nu[k] <= nu[k-1];
				nv[k] <= nv[k-1];
			end
		end
	end

	// Control and item fields, with the drop decisions folded into keep.
	always_comb begin
		ctl_d[1].valid      = in_valid;
		ctl_d[1].item.cmd   = in_req.cmd;
		ctl_d[1].item.addr  = lpcc_pkg::ADDR_W'(in_req.row) *
		                      lpcc_pkg::ADDR_W'(lpcc_pkg::IMAGE_WIDTH) +
		                      lpcc_pkg::ADDR_W'(in_req.col);
		ctl_d[1].item.color = in_req.color;
		ctl_d[1].item.x     = in_req.x;
		ctl_d[1].item.y     = in_req.y;
		ctl_d[1].item.z     = in_req.z;
		ctl_d[1].keep       = (in_req.cmd == lpcc_pkg::CMD_POINT) ||
		                      ((32'(in_req.row) < lpcc_pkg::IMAGE_HEIGHT) &&
		                       (32'(in_req.col) < lpcc_pkg::IMAGE_WIDTH));
		for (int k = 2; k <= NS; k++) ctl_d[k] = ctl_q[k-1];
		// Zero depth term or x not positive.
		if (ctl_q[3].item.cmd == lpcc_pkg::CMD_POINT)
			ctl_d[4].keep = ctl_q[3].keep && (t_s3[2] != '0) && x_pos_s3;
		// A quotient of 2**Q_W or more is off the frame whatever its sign.
		if (ctl_q[4].item.cmd == lpcc_pkg::CMD_POINT)
			ctl_d[5].keep = ctl_q[4].keep &&
			                ({{lpcc_pkg::Q_W{1'b0}}, mu_s4} < lim_s5) &&
			                ({{lpcc_pkg::Q_W{1'b0}}, mv_s4} < lim_s5);
		if (ctl_q[NS-1].item.cmd == lpcc_pkg::CMD_POINT) begin
			ctl_d[NS].keep = ctl_q[NS-1].keep &&
			                 !(nu[lpcc_pkg::Q_W] && qu[lpcc_pkg::Q_W] != '0) &&
			                 !(nv[lpcc_pkg::Q_W] && qv[lpcc_pkg::Q_W] != '0) &&
			                 (32'(qu[lpcc_pkg::Q_W]) < lpcc_pkg::IMAGE_WIDTH) &&
			                 (32'(qv[lpcc_pkg::Q_W]) < lpcc_pkg::IMAGE_HEIGHT);
			ctl_d[NS].item.addr = lpcc_pkg::ADDR_W'(qv[lpcc_pkg::Q_W]) *
			                      lpcc_pkg::ADDR_W'(lpcc_pkg::IMAGE_WIDTH) +
			                      lpcc_pkg::ADDR_W'(qu[lpcc_pkg::Q_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++) ctl_q[k] <= '0;
		end else if (en) begin
			for (int k = 1; k <= NS; k++) ctl_q[k] <= ctl_d[k];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/lpcc_queue.sv -----
// ----------------------------------------------------------------------------
// lpcc_queue: short item queue between front end and frame store
// A four-entry first-in first-out buffer with a fill count.
// ----------------------------------------------------------------------------
`default_nettype none
module lpcc_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  lpcc_pkg::item_t      push_item,
	output logic                 full,
	input  wire                  pop,
	output logic                 empty,
	output lpcc_pkg::item_t      head
);

	lpcc_pkg::item_t                buf_q [lpcc_pkg::Q_DEPTH];
	logic [lpcc_pkg::QPTR_W-1:0]    wr_q, rd_q;
	logic [lpcc_pkg::QCNT_W-1:0]    cnt_q;

	assign full  = (cnt_q == lpcc_pkg::QCNT_W'(lpcc_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/lpcc_back.sv -----
// ----------------------------------------------------------------------------
// lpcc_back: frame store and result register
// Writes pixels into the frame store and looks up the color of kept points.
// ----------------------------------------------------------------------------
`default_nettype none
module lpcc_back (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 q_empty,
	input  lpcc_pkg::item_t                     q_head,
	output logic                                pop,
	output logic                                m_valid,
	input  wire                                 m_ready,
	output logic signed [lpcc_pkg::COORD_W-1:0] m_x,
	output logic signed [lpcc_pkg::COORD_W-1:0] m_y,
	output logic signed [lpcc_pkg::COORD_W-1:0] m_z,
	output logic [lpcc_pkg::COLOR_W-1:0]        m_color
);

	logic [lpcc_pkg::COLOR_W-1:0]  frame_q [lpcc_pkg::PIX_N];
	logic [lpcc_pkg::COLOR_W-1:0]  rd_s1;
	lpcc_pkg::item_t               pt_s1;
	logic                          v_s1;
	logic                          adv;

	assign adv = !m_valid || m_ready;
	assign pop = !q_empty && adv;

	always_ff @(posedge clk) begin
		if (pop && q_head.cmd == lpcc_pkg::CMD_PIXEL) frame_q[q_head.addr] <= q_head.color;
		if (pop && q_head.cmd == lpcc_pkg::CMD_POINT) rd_s1 <= frame_q[q_head.addr];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s1   <= q_head;
			m_x     <= pt_s1.x;
			m_y     <= pt_s1.y;
			m_z     <= pt_s1.z;
			m_color <= rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			m_valid <= 1'b0;
		end else if (adv) begin
			v_s1    <= pop && (q_head.cmd == lpcc_pkg::CMD_POINT);
			m_valid <= v_s1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/lpcc_checker.sv -----
// ----------------------------------------------------------------------------
// lpcc_checker: port-level checks of the lidar point colorizer
// Watches the result stream for stall behavior, reset and kept-point rules.
// ----------------------------------------------------------------------------
`default_nettype none
module lpcc_checker (
	input wire          clk,
	input wire          arst_n,
	input wire          s_tready,
	input wire          m_tvalid,
	input wire          m_tready,
	input wire [95:0]   m_tdata
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Only points with positive x are ever emitted.
	a_xpos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[23] && (m_tdata[23:0] != 24'd0))
		else $error("result with non-positive x");

	// No result is shown once reset has been seen at a clock edge.
	a_rst: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result during reset");

	// The input side is ready right after reset.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> s_tready)
		else $error("input stalled right after reset");

endmodule

bind lidar_point_camera_colorizer lpcc_checker u_lpcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

// ----- dv/lidar_point_camera_colorizer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_point_camera_colorizer_tb: self-checking bench for the point colorizer
// Pixel and point requests are streamed into the block under random idling on
// both sides. A predictor in the bench projects each accepted point and looks
// up the pixel, and every result is compared field by field against it.
// ----------------------------------------------------------------------------
`default_nettype none
module lidar_point_camera_colorizer_tb;

	localparam int CYCLE_LIMIT = 300000;
	// This covers anything still in flight in the pipeline.
	localparam int DRAIN_CYCLES = 40;
	localparam int IMG_W = lpcc_pkg::IMAGE_WIDTH;
	localparam int IMG_H = lpcc_pkg::IMAGE_HEIGHT;

	// One request as the bench sees it, before it is packed onto s_tdata.
	typedef struct {
		lpcc_pkg::cmd_t               cmd;
		logic [lpcc_pkg::ROW_W-1:0]   row;
		logic [lpcc_pkg::COL_W-1:0]   col;
		logic [7:0]                   blue, green, red;
		logic signed [23:0]           x, y, z;
	} colorizer_req_t;

	// One colored point as it should leave the block.
	typedef struct {
		logic [23:0] x, y, z;
		logic [7:0]  blue, green, red;
	} colored_point_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [lpcc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [lpcc_pkg::REG_W-1:0]     cfg_data = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic                           s_tuser = 1'b0;
	logic [119:0]                   s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [95:0]                    m_tdata;

	lidar_point_camera_colorizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: the sign-extended matrix and the pixels written so far.
	longint         proj_coef [3][4];
	logic [23:0]    frame_pix [int unsigned];
	// Pixels that the stimulus has already queued a write for; points are only
	// aimed at pixels in this set, so no unwritten pixel is ever read.
	bit             pix_queued [int unsigned];

	colorizer_req_t req_q [$];
	colored_point_t colored_q [$];

	int  mismatch_cnt = 0;
	int  pixel_cnt = 0, point_cnt = 0, colored_cnt = 0, phase_cnt = 0;
	int  cycle_cnt = 0;
	bit  no_idle = 1'b0;
	int  in_gap = 0, out_stall = 0;

	// Camera aim of the current phase, used only to steer random points into
	// the frame; prediction always goes through the matrix itself.
	int  aim_fx, aim_fy, aim_cx, aim_cy;

	// Projects a point through the matrix. Returns 1 with the frame address
	// when the point is kept: nonzero depth, positive x and inside the frame.
	function automatic bit project_point(input logic signed [23:0] px, py, pz,
			output int unsigned addr);
		longint xv, yv, zv, c, r;
		longint s [3];
		xv = px;
		yv = py;
		zv = pz;
		addr = 0;
		for (int k = 0; k < 3; k++) begin
			s[k] = proj_coef[k][0] * xv + proj_coef[k][1] * yv +
				proj_coef[k][2] * zv + proj_coef[k][3] * 1024;
		end
		if (s[2] == 0 || xv <= 0) return 1'b0;
		// Integer division of longint truncates toward zero, as the block does.
		c = s[0] / s[2];
		r = s[1] / s[2];
		if (c < 0 || c >= IMG_W || r < 0 || r >= IMG_H) return 1'b0;
		addr = int'(r * IMG_W + c);
		return 1'b1;
	endfunction

	// Updates the predictor for one accepted request.
	task automatic colorize_request(input colorizer_req_t rq);
		int unsigned    addr;
		colored_point_t cp;
		if (rq.cmd == lpcc_pkg::CMD_PIXEL) begin
			pixel_cnt++;
			if (rq.row < IMG_H && rq.col < IMG_W)
				frame_pix[rq.row * IMG_W + rq.col] = {rq.red, rq.green, rq.blue};
		end else begin
			point_cnt++;
			if (project_point(rq.x, rq.y, rq.z, addr)) begin
				cp.x = rq.x;
				cp.y = rq.y;
				cp.z = rq.z;
				{cp.red, cp.green, cp.blue} = frame_pix.exists(addr) ? frame_pix[addr] : 24'h0;
				colored_q = {colored_q, cp};
			end
		end
	endtask

	function automatic void queue_pixel(input int row, col, input logic [23:0] bgr);
		colorizer_req_t rq;
		rq.cmd = lpcc_pkg::CMD_PIXEL;
		rq.row = row[10:0];
		rq.col = col[10:0];
		{rq.red, rq.green, rq.blue} = bgr;
		rq.x = 24'($urandom);
		rq.y = 24'($urandom);
		rq.z = 24'($urandom);
		if (rq.row < IMG_H && rq.col < IMG_W)
			pix_queued[rq.row * IMG_W + rq.col] = 1'b1;
		req_q = {req_q, rq};
	endfunction

	// Queues a point; if it lands on a pixel with no write yet, the pixel is
	// written first with a random color.
	function automatic void queue_point(input logic signed [23:0] px, py, pz);
		colorizer_req_t rq;
		int unsigned    addr;
		if (project_point(px, py, pz, addr) && !pix_queued.exists(addr))
			queue_pixel(addr / IMG_W, addr % IMG_W, 24'($urandom));
		rq.cmd = lpcc_pkg::CMD_POINT;
		rq.row = 11'($urandom);
		rq.col = 11'($urandom);
		{rq.red, rq.green, rq.blue} = 24'($urandom);
		rq.x = px;
		rq.y = py;
		rq.z = pz;
		req_q = {req_q, rq};
	endfunction

	// Aims a point at a random spot around the frame using the phase's camera.
	function automatic void queue_aimed_point();
		longint xv, yv, zv, c, r;
		xv = $urandom_range(512, 40000);
		c = longint'($urandom_range(0, IMG_W + 80)) - 40;
		r = longint'($urandom_range(0, IMG_H + 80)) - 40;
		yv = (aim_cx - c) * xv / aim_fx;
		zv = (aim_cy - r) * xv / aim_fy;
		queue_point(24'(xv), 24'(yv), 24'(zv));
	endfunction

	// Register writes happen back to back; the enable is lowered by the caller.
	task automatic write_reg(input logic [lpcc_pkg::CFG_IDX_W-1:0] idx,
			input logic [63:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx < lpcc_pkg::NUM_REGS) begin
			proj_coef[idx / 2][(idx % 2) * 2]     = longint'(signed'(val[31:0]));
			proj_coef[idx / 2][(idx % 2) * 2 + 1] = longint'(signed'(val[63:32]));
		end
	endtask

	task automatic end_reg_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Pinhole camera looking along +x: column = cx - fx*y/x, row = cy - fy*z/x.
	// Each coefficient is Q16.16; jit adds random fractions and an offset.
	task automatic load_pinhole(input int fx, fy, cx, cy, input int tw, input bit jit);
		logic [31:0] q [3][4];
		aim_fx = fx;
		aim_fy = fy;
		aim_cx = cx;
		aim_cy = cy;
		q[0] = '{32'(cx * 65536), 32'(-fx * 65536), 32'd0, 32'd0};
		q[1] = '{32'(cy * 65536), 32'd0, 32'(-fy * 65536), 32'd0};
		q[2] = '{32'd65536, 32'd0, 32'd0, 32'(tw * 65536)};
		if (jit) begin
			q[0][0] += $urandom_range(0, 65535);
			q[0][1] -= $urandom_range(0, 65535);
			q[0][3] = 32'($urandom_range(0, 20 * 65536)) - 32'(10 * 65536);
			q[1][0] += $urandom_range(0, 65535);
			q[1][2] -= $urandom_range(0, 65535);
			q[1][3] = 32'($urandom_range(0, 20 * 65536)) - 32'(10 * 65536);
		end
		write_reg(lpcc_pkg::REG_R0_C01, {q[0][1], q[0][0]});
		write_reg(lpcc_pkg::REG_R0_C23, {q[0][3], q[0][2]});
		write_reg(lpcc_pkg::REG_R1_C01, {q[1][1], q[1][0]});
		write_reg(lpcc_pkg::REG_R1_C23, {q[1][3], q[1][2]});
		write_reg(lpcc_pkg::REG_R2_C01, {q[2][1], q[2][0]});
		write_reg(lpcc_pkg::REG_R2_C23, {q[2][3], q[2][2]});
		end_reg_writes();
	endtask

	task automatic load_uniform(input logic [31:0] coef);
		for (int i = 0; i < lpcc_pkg::NUM_REGS; i++)
			write_reg(lpcc_pkg::CFG_IDX_W'(i), {coef, coef});
		end_reg_writes();
	endtask

	// Matrix changes are only made with the block drained. Pixel writes give
	// no result, so a pipeline's worth of cycles passes after the last one.
	task automatic wait_drained();
		while (req_q.size() != 0 || colored_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		phase_cnt++;
	endtask

	// Random mix: when aimed, mostly points aimed around the frame; else mostly
	// points with fully random coordinates; pixel writes now and then fall outside.
	function automatic void queue_random_mix(input int n, input bit aimed);
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 25) begin
				if ($urandom_range(0, 9) == 0)
					queue_pixel($urandom_range(0, 2047), $urandom_range(0, 2047), 24'($urandom));
				else
					queue_pixel($urandom_range(0, IMG_H - 1),
						$urandom_range(0, IMG_W - 1), 24'($urandom));
			end else if (aimed && sel < 85) begin
				queue_aimed_point();
			end else begin
				queue_point(24'($urandom), 24'($urandom), 24'($urandom));
			end
		end
	endfunction

	// Request driver. The head of req_q is presented until accepted; a gap is
	// only opened when no request is pending on the bus.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				colorize_request(req_q.pop_front());
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (in_gap > 0) begin
				in_gap--;
				s_tvalid <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				in_gap = $urandom_range(0, 5);
				s_tvalid <= 1'b0;
			end else if (req_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tuser  <= req_q[0].cmd;
				s_tdata  <= {2'b00, req_q[0].z, req_q[0].y, req_q[0].x, req_q[0].red,
					req_q[0].green, req_q[0].blue, req_q[0].col, req_q[0].row};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		colored_point_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				colored_cnt++;
				if (colored_q.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("%0t: result with nothing expected: %h", $realtime, m_tdata);
					mismatch_cnt++;
				end else begin
					want = colored_q.pop_front();
					if (m_tdata[23:0] !== want.x || m_tdata[47:24] !== want.y ||
							m_tdata[71:48] !== want.z || m_tdata[79:72] !== want.blue ||
							m_tdata[87:80] !== want.green || m_tdata[95:88] !== want.red) begin
						if (mismatch_cnt < 10)
							$display("%0t: expected x=%h y=%h z=%h bgr=%h/%h/%h, ",
								$realtime, want.x, want.y, want.z, want.blue, want.green,
								want.red, "got x=%h y=%h z=%h bgr=%h/%h/%h",
								m_tdata[23:0], m_tdata[47:24], m_tdata[71:48],
								m_tdata[79:72], m_tdata[87:80], m_tdata[95:88]);
						mismatch_cnt++;
					end
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				m_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				out_stall = $urandom_range(0, 5);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_cnt);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		foreach (proj_coef[r, c]) proj_coef[r][c] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset matrix is all zero, so every point has zero depth and is dropped.
		// Writes to the two indexes past the last register must change nothing.
		write_reg(lpcc_pkg::CFG_IDX_W'(lpcc_pkg::NUM_REGS), 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(lpcc_pkg::CFG_IDX_W'(lpcc_pkg::NUM_REGS + 1), 64'h0001_0000_0001_0000);
		end_reg_writes();
		queue_pixel(0, 0, 24'h000000);
		queue_pixel(IMG_H - 1, IMG_W - 1, 24'hFFFFFF);
		queue_point(24'sd1024, 24'sd0, 24'sd0);
		queue_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
		wait_drained();

		// Directed cases with an exact camera: fx = fy = 1000, center 960/540.
		load_pinhole(1000, 1000, 960, 540, 0, 1'b0);
		queue_pixel(2047, 2047, 24'hA5A5A5);           // both coordinates outside
		queue_pixel(IMG_H, 5, 24'h123456);             // row just past the frame
		queue_pixel(5, IMG_W, 24'h654321);             // column just past the frame
		queue_point(24'sd1024, 24'sd0, 24'sd0);        // frame center
		queue_point(24'sd1024, 24'sd983, 24'sd553);    // quotients just either side of 0, both kept as 0
		queue_point(24'sd1024, 24'sd984, 24'sd554);    // column quotient in (-1, 0), row quotient under -1
		queue_point(24'sd1024, 24'sd1000, 24'sd0);     // left of the frame
		queue_point(24'sd1024, -24'sd983, -24'sd552);  // near the far corner
		queue_point(24'sd1024, -24'sd1000, 24'sd0);    // right of the frame
		queue_point(24'sd1024, 24'sd0, -24'sd600);     // below the frame
		queue_point(24'sd0, 24'sd0, 24'sd0);           // x zero
		queue_point(-24'sd1024, 24'sd0, 24'sd0);       // x negative
		queue_point(-24'sh800000, 24'sd0, 24'sd0);     // most negative x
		queue_point(24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000);
		queue_point(24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF);
		queue_point(24'sh7FFFFF, 24'sd0, 24'sd0);
		wait_drained();

		// Depth term with an offset: x = 64 m gives exactly zero depth.
		load_pinhole(1000, 1000, 960, 540, -64, 1'b0);
		queue_point(24'sd65536, 24'sd0, 24'sd0);
		queue_point(24'sd131072, 24'sd0, 24'sd0);
		queue_random_mix(60, 1'b1);
		wait_drained();

		// Uniform extreme matrices: every row is equal, so kept points land on (1, 1).
		load_uniform(32'h7FFF_FFFF);
		queue_random_mix(50, 1'b0);
		wait_drained();
		load_uniform(32'h8000_0000);
		queue_random_mix(50, 1'b0);
		wait_drained();
		load_uniform(32'hFFFF_FFFF);
		queue_random_mix(40, 1'b0);
		wait_drained();

		// Fully random registers.
		for (int i = 0; i < lpcc_pkg::NUM_REGS; i++)
			write_reg(lpcc_pkg::CFG_IDX_W'(i), {$urandom, $urandom});
		end_reg_writes();
		queue_random_mix(60, 1'b0);
		wait_drained();

		// Random cameras with fractional coefficients and offsets.
		for (int ph = 0; ph < 5; ph++) begin
			load_pinhole($urandom_range(200, 1500), $urandom_range(200, 1500),
				$urandom_range(800, 1100), $urandom_range(400, 700), 0, 1'b1);
			if (ph == 4) no_idle = 1'b1;
			queue_random_mix(85, 1'b1);
			wait_drained();
		end

		$display("Covered %0d pixel writes and %0d points over %0d matrix settings.",
			pixel_cnt, point_cnt, phase_cnt);
		$display("%0d colored points came out and were checked.", colored_cnt);
		if (mismatch_cnt == 0 && colored_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_cnt, colored_q.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire
